// File: design/rrsa_pkg.sv
// Shared types, constants and helper functions for the round-robin server assigner.
// Used by rrsa_cell and round_robin_server_assigner; depends on nothing.
`default_nettype none

package rrsa_pkg;

	// Pool geometry
	localparam int MAX_SERVERS = 16;
	localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

	// Field widths
	localparam int CFG_W  = 5;
	localparam int TIME_W = 30;
	localparam int WORD_W = 32;
	localparam int SIDX_W = 4;

	// Command codes
	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	localparam logic [WORD_W-1:0] COUNT_SAT = {WORD_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REQ_CMP,
		ST_REQ_PICK,
		ST_RPT_MAX,
		ST_RPT_HIT
	} state_t;

	// Token that walks the row of cells during a report
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] best;
	} link_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic              scan_hit;
		logic [TIME_W-1:0] arrival;
		logic [WORD_W-1:0] busy_new;
	} cell_ctrl_t;

	// Number of servers in use, clamped to 1..MAX_SERVERS
	function automatic logic [CNT_W-1:0] pool_size(input logic [CFG_W-1:0] n);
		int unsigned nv;
		logic [CNT_W-1:0] k;
		nv = n;
		if (nv == 0) begin
			k = CNT_W'(1);
		end else if (nv > MAX_SERVERS) begin
			k = CNT_W'(MAX_SERVERS);
		end else begin
			k = CNT_W'(nv);
		end
		return k;
	endfunction

	// Keep only the lowest set bit
	function automatic logic [MAX_SERVERS-1:0] lowest_onehot(input logic [MAX_SERVERS-1:0] v);
		return v & (~v + MAX_SERVERS'(1));
	endfunction

	// Encode a one-hot vector as an index
	function automatic logic [IDX_W-1:0] onehot_to_index(input logic [MAX_SERVERS-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < MAX_SERVERS; i++) begin
			if (v[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// File: design/round_robin_server_assigner.sv
// Top level of the round-robin server assigner: sequencer, rotating pick and
// the row of rrsa_cell instances. Depends on rrsa_pkg and rrsa_cell.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  command   | start / busy               | command, arrival_time, load_time
//  result    | result_valid (one cycle)   | server_index, no_server, served_count,
//            |                            | last_of_run
//  config    | cfg_we                     | cfg_data (num_servers)
//
// An assign request passes through ST_REQ_CMP (parallel free compare in the
// cells) and ST_REQ_PICK (rotating pick and update); its result is registered.
// A report walks the token through the row of MAX_SERVERS cells twice (maximum,
// then matches); its results leave one per match.
// busy is high while an item is at work. Reset clears all times, counts and the
// position at once. The receiver cannot stall: each result is valid for one cycle.
`default_nettype none

module round_robin_server_assigner
	import rrsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              command,
	input  wire logic [TIME_W-1:0] arrival_time,
	input  wire logic [TIME_W-1:0] load_time,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic                   result_valid,
	output logic [SIDX_W-1:0]      server_index,
	output logic                   no_server,
	output logic [WORD_W-1:0]      served_count,
	output logic                   last_of_run
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]       num_servers_q;
	logic [IDX_W-1:0]       pos_q, pos_d;
	logic [TIME_W-1:0]      arrival_s1;
	logic [TIME_W-1:0]      load_s1;
	logic [MAX_SERVERS-1:0] free_s2;
	link_t                  seed_q, seed_d;
	logic [WORD_W-1:0]      best_q, best_d;
	logic                   pend_vld_q, pend_vld_d;
	logic [IDX_W-1:0]       pend_idx_q, pend_idx_d;

	logic                   res_vld_q, res_vld_d;
	logic [SIDX_W-1:0]      res_idx_q, res_idx_d;
	logic                   res_none_q, res_none_d;
	logic [WORD_W-1:0]      res_cnt_q, res_cnt_d;
	logic                   res_last_q, res_last_d;

	logic [CNT_W-1:0]       pool_k;
	logic [IDX_W-1:0]       pref;
	logic [CNT_W-1:0]       pref_inc;
	logic [MAX_SERVERS-1:0] ge_mask;
	logic [MAX_SERVERS-1:0] pick_oh;
	logic [MAX_SERVERS-1:0] upd_vec;
	logic [MAX_SERVERS-1:0] in_pool;
	logic [MAX_SERVERS-1:0] free_vec;
	logic [MAX_SERVERS-1:0] hit_vec;
	logic [WORD_W-1:0]      cnt_arr  [MAX_SERVERS];
	link_t                  link_arr [MAX_SERVERS];
	logic [WORD_W-1:0]      pick_cnt;
	logic [WORD_W-1:0]      pick_cnt_inc;
	logic                   found;
	cell_ctrl_t             ctrl;
	logic                   accept;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign pool_k = pool_size(num_servers_q);

	// Preferred server: a stale position acts as zero
	assign pref     = (CNT_W'(pos_q) < pool_k) ? pos_q : '0;
	assign pref_inc = CNT_W'(pref) + CNT_W'(1);

	// Rotating pick: first free at or after pref, else first free overall
	always_comb begin
		for (int i = 0; i < MAX_SERVERS; i++) begin
			ge_mask[i] = (IDX_W'(i) >= pref);
		end
	end

	assign found   = |free_s2;
	assign pick_oh = (|(free_s2 & ge_mask)) ? lowest_onehot(free_s2 & ge_mask)
	                                        : lowest_onehot(free_s2);
	assign upd_vec = (state_q == ST_REQ_PICK && found) ? pick_oh : '0;

	// Select the chosen server's count
	always_comb begin
		pick_cnt = '0;
		for (int i = 0; i < MAX_SERVERS; i++) begin
			if (pick_oh[i]) begin
				pick_cnt = pick_cnt | cnt_arr[i];
			end
		end
	end
	assign pick_cnt_inc = (pick_cnt == COUNT_SAT) ? pick_cnt : pick_cnt + WORD_W'(1);

	// Broadcast controls
	assign ctrl.scan_hit = (state_q == ST_RPT_HIT);
	assign ctrl.arrival  = arrival_s1;
	assign ctrl.busy_new = {{(WORD_W-TIME_W){1'b0}}, arrival_s1}
	                     + {{(WORD_W-TIME_W){1'b0}}, load_s1};

	// Row of server cells
	for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
		assign in_pool[g] = (CNT_W'(g) < pool_k);
		rrsa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_pool  (in_pool[g]),
			.ctrl     (ctrl),
			.upd      (upd_vec[g]),
			.link_in  ((g == 0) ? seed_q : link_arr[(g == 0) ? 0 : g - 1]),
			.link_out (link_arr[g]),
			.free     (free_vec[g]),
			.hit      (hit_vec[g]),
			.count    (cnt_arr[g])
		);
	end

	// Next state, token injection and result loads
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		seed_d     = '0;
		best_d     = best_q;
		pend_vld_d = pend_vld_q;
		pend_idx_d = pend_idx_q;
		res_vld_d  = 1'b0;
		res_idx_d  = res_idx_q;
		res_none_d = res_none_q;
		res_cnt_d  = res_cnt_q;
		res_last_d = res_last_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_REPORT) begin
						seed_d.valid = 1'b1;
						state_d      = ST_RPT_MAX;
					end else begin
						state_d = ST_REQ_CMP;
					end
				end
			end
			ST_REQ_CMP: begin
				state_d = ST_REQ_PICK;
			end
			ST_REQ_PICK: begin
				pos_d      = (pref_inc >= pool_k) ? '0 : IDX_W'(pref_inc);
				res_vld_d  = 1'b1;
				res_last_d = 1'b1;
				res_none_d = !found;
				res_idx_d  = found ? SIDX_W'(onehot_to_index(pick_oh)) : '0;
				res_cnt_d  = found ? pick_cnt_inc : '0;
				state_d    = ST_IDLE;
			end
			ST_RPT_MAX: begin
				if (link_arr[MAX_SERVERS-1].valid) begin
					best_d      = link_arr[MAX_SERVERS-1].best;
					seed_d.valid = 1'b1;
					seed_d.best  = link_arr[MAX_SERVERS-1].best;
					pend_vld_d  = 1'b0;
					state_d     = ST_RPT_HIT;
				end
			end
			ST_RPT_HIT: begin
				// Emit the held match once the next one shows or the pass ends
				if (|hit_vec) begin
					if (pend_vld_q) begin
						res_vld_d  = 1'b1;
						res_last_d = 1'b0;
						res_none_d = 1'b0;
						res_idx_d  = SIDX_W'(pend_idx_q);
						res_cnt_d  = best_q;
					end
					pend_vld_d = 1'b1;
					pend_idx_d = onehot_to_index(hit_vec);
				end else if (link_arr[MAX_SERVERS-1].valid) begin
					res_vld_d  = 1'b1;
					res_last_d = 1'b1;
					res_none_d = 1'b0;
					res_idx_d  = SIDX_W'(pend_idx_q);
					res_cnt_d  = best_q;
					pend_vld_d = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			num_servers_q <= CFG_W'(MAX_SERVERS);
			pos_q         <= '0;
			seed_q        <= '0;
			pend_vld_q    <= 1'b0;
			res_vld_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			seed_q     <= seed_d;
			pend_vld_q <= pend_vld_d;
			res_vld_q  <= res_vld_d;
			if (cfg_we) begin
				num_servers_q <= cfg_data;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			arrival_s1 <= arrival_time;
			load_s1    <= load_time;
		end
		if (state_q == ST_REQ_CMP) begin
			free_s2 <= free_vec;
		end
		best_q     <= best_d;
		pend_idx_q <= pend_idx_d;
		res_idx_q  <= res_idx_d;
		res_none_q <= res_none_d;
		res_cnt_q  <= res_cnt_d;
		res_last_q <= res_last_d;
	end

	assign result_valid = res_vld_q;
	assign server_index = res_idx_q;
	assign no_server    = res_none_q;
	assign served_count = res_cnt_q;
	assign last_of_run  = res_last_q;

	// A dropped request reports server zero with a zero count
	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && no_server) |-> (server_index == '0 && served_count == '0 && last_of_run))
		else $error("dropped request carries nonzero fields");

	// At most one cell takes a request
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(upd_vec))
		else $error("more than one cell updated");

	// The report token meets one cell at a time
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("several cells hit in one cycle");

	// A result that is not last belongs to a report still in progress
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |-> (state_q == ST_RPT_HIT))
		else $error("non-final result outside a report");

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start work");

endmodule

`default_nettype wire

// File: design/rrsa_cell.sv
// One server cell: holds busy-until time and served count, checks freeness,
// and passes the report token to its neighbor. Depends on rrsa_pkg.
`default_nettype none

module rrsa_cell
	import rrsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_pool,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic              upd,
	input  wire link_t             link_in,
	output link_t                  link_out,
	output logic                   free,
	output logic                   hit,
	output logic [WORD_W-1:0]      count
);

	logic [WORD_W-1:0] busy_q;
	logic [WORD_W-1:0] count_q;
	link_t             link_q;
	link_t             link_d;

	// Compare own busy-until time with the request's arrival
	assign free  = in_pool && (busy_q <= {{(WORD_W-TIME_W){1'b0}}, ctrl.arrival});
	assign count = count_q;

	// Flag a busiest server as the second report pass goes by
	assign hit = ctrl.scan_hit && link_in.valid && in_pool && (count_q == link_in.best);

	// Fold own count into the running maximum, or pass the best count on
	always_comb begin
		link_d = link_in;
		if (!ctrl.scan_hit && in_pool && (count_q > link_in.best)) begin
			link_d.best = count_q;
		end
	end

	// Hold server state; update it when this cell takes a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			count_q      <= '0;
			link_q.valid <= 1'b0;
			link_q.best  <= '0;
		end else begin
			link_q <= link_d;
			if (upd) begin
				busy_q <= ctrl.busy_new;
				if (count_q != COUNT_SAT) begin
					count_q <= count_q + WORD_W'(1);
				end
			end
		end
	end

	assign link_out = link_q;

endmodule

`default_nettype wire

// File: tb/sv/round_robin_server_assigner_tb.sv
// Self-checking testbench for round_robin_server_assigner: driver, monitor and a
// model of the server pool that predicts every result item.
// Depends on rrsa_pkg and the round_robin_server_assigner RTL.
module round_robin_server_assigner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrsa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int TAIL_CYCLES = 2 * MAX_SERVERS + 24;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 35;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct {
		logic              cmd;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] ld;
	} request_t;

	typedef struct {
		logic [SIDX_W-1:0] idx;
		logic              none;
		logic [WORD_W-1:0] cnt;
		logic              last;
	} outcome_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              command      = CMD_ASSIGN;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [TIME_W-1:0] load_time    = '0;
	logic              cfg_we       = 1'b0;
	logic [CFG_W-1:0]  cfg_data     = '0;
	logic              busy;
	logic              result_valid;
	logic [SIDX_W-1:0] server_index;
	logic              no_server;
	logic [WORD_W-1:0] served_count;
	logic              last_of_run;

	// Pool model
	logic [WORD_W-1:0] srv_busy_until [MAX_SERVERS];
	logic [WORD_W-1:0] srv_served     [MAX_SERVERS];
	int unsigned       next_pref;
	logic [CFG_W-1:0]  pool_setting;

	request_t queued_requests[$];
	outcome_t expected_outcomes[$];

	int mismatches   = 0;
	int accepted     = 0;
	int n_reports    = 0;
	int n_drops      = 0;
	int n_checked    = 0;
	int n_settings   = 1;
	int cycles       = 0;

	round_robin_server_assigner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.arrival_time (arrival_time),
		.load_time    (load_time),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.server_index (server_index),
		.no_server    (no_server),
		.served_count (served_count),
		.last_of_run  (last_of_run)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Model the block's response to one accepted item
	task automatic predict_assignment(input logic cmd, input logic [TIME_W-1:0] arr,
	                                  input logic [TIME_W-1:0] ld);
		int unsigned       k;
		int unsigned       pref;
		int unsigned       cand;
		int unsigned       chosen;
		int unsigned       last_hit;
		logic [WORD_W-1:0] best;
		logic              found;
		outcome_t          o;
		k = (pool_setting == 0) ? 1 :
		    ((pool_setting > MAX_SERVERS) ? MAX_SERVERS : pool_setting);
		if (cmd == CMD_REPORT) begin
			n_reports++;
			best = '0;
			last_hit = 0;
			for (int s = 0; s < k; s++)
				if (srv_served[s] > best) best = srv_served[s];
			for (int s = 0; s < k; s++)
				if (srv_served[s] == best) last_hit = s;
			for (int s = 0; s < k; s++) begin
				if (srv_served[s] == best) begin
					o.idx  = SIDX_W'(s);
					o.none = 1'b0;
					o.cnt  = best;
					o.last = (s == last_hit);
					expected_outcomes.push_back(o);
				end
			end
		end else begin
			pref   = (next_pref < k) ? next_pref : 0;
			found  = 1'b0;
			chosen = 0;
			// Scan from the preferred server, wrapping round the pool
			for (int unsigned step = 0; step < k; step++) begin
				cand = pref + step;
				if (cand >= k) cand -= k;
				if (!found && srv_busy_until[cand] <= {2'b00, arr}) begin
					found  = 1'b1;
					chosen = cand;
				end
			end
			next_pref = (pref + 1 >= k) ? 0 : pref + 1;
			o.last = 1'b1;
			if (!found) begin
				n_drops++;
				o.idx  = '0;
				o.none = 1'b1;
				o.cnt  = '0;
			end else begin
				srv_busy_until[chosen] = {2'b00, arr} + {2'b00, ld};
				if (srv_served[chosen] != COUNT_SAT) srv_served[chosen]++;
				o.idx  = SIDX_W'(chosen);
				o.none = 1'b0;
				o.cnt  = srv_served[chosen];
			end
			expected_outcomes.push_back(o);
		end
	endtask

	task automatic add_req(input logic cmd, input logic [TIME_W-1:0] arr,
	                       input logic [TIME_W-1:0] ld);
		request_t rq;
		rq.cmd = cmd;
		rq.arr = arr;
		rq.ld  = ld;
		queued_requests.push_back(rq);
	endtask

	// Hold until every queued item is taken and every result has come back;
	// sample on the falling edge so driver and monitor updates have settled
	task automatic wait_drained();
		int n;
		n = 0;
		while (n < DRAIN_LIMIT && (queued_requests.size() != 0 || start || busy ||
		       expected_outcomes.size() != 0)) begin
			@(negedge clk);
			n++;
		end
	endtask

	// Write the pool size once the block is idle
	task automatic set_pool(input logic [CFG_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		pool_setting  = v;
		n_settings++;
		@(negedge clk);
	endtask

	// Driver: present queued items, idle at random outside the quiet stretch
	always @(posedge clk) begin : drive_proc
		logic     take_next;
		logic     idle_ok;
		request_t rq;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			take_next = !start;
			if (start && !busy) begin
				predict_assignment(command, arrival_time, load_time);
				accepted++;
				take_next = 1'b1;
			end
			idle_ok = !(accepted >= 180 && accepted < 280);
			if (take_next) begin
				if (queued_requests.size() != 0 && !(idle_ok && $urandom_range(0, 99) < 22)) begin
					rq = queued_requests.pop_front();
					command      <= rq.cmd;
					arrival_time <= rq.arr;
					load_time    <= rq.ld;
					start        <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin : check_proc
		outcome_t e;
		if (arst_n && result_valid) begin
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual idx=%0d none=%0b cnt=%0d last=%0b",
				         $time, server_index, no_server, served_count, last_of_run);
			end else begin
				e = expected_outcomes.pop_front();
				n_checked++;
				if (server_index !== e.idx || no_server !== e.none ||
				    served_count !== e.cnt || last_of_run !== e.last) begin
					mismatches++;
					$display("%0t: mismatch: expected idx=%0d none=%0b cnt=%0d last=%0b, actual idx=%0d none=%0b cnt=%0d last=%0b",
					         $time, e.idx, e.none, e.cnt, e.last,
					         server_index, no_server, served_count, last_of_run);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("round_robin_server_assigner_tb failed");
			$finish;
		end
	end

	initial begin : stim_proc
		int unsigned      r;
		int unsigned      arr;
		int unsigned      ld;
		int unsigned      t_now;
		logic [CFG_W-1:0] pool_v;
		logic             last_phase;
		for (int s = 0; s < MAX_SERVERS; s++) begin
			srv_busy_until[s] = '0;
			srv_served[s]     = '0;
		end
		next_pref    = 0;
		pool_setting = CFG_W'(MAX_SERVERS);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full pool after reset: all counts tied at zero, then a few assigns
		add_req(CMD_REPORT, '0, 30'd1);
		add_req(CMD_ASSIGN, '0, 30'd1);
		add_req(CMD_ASSIGN, '0, 30'd3);
		add_req(CMD_ASSIGN, 30'd5, 30'd2);
		add_req(CMD_REPORT, TIME_MAX, TIME_MAX);

		// Shrink below the position, fill the pool, free on equal time, drop,
		// then drop again on a decreasing arrival time
		set_pool(5'd3);
		add_req(CMD_ASSIGN, 30'd5, 30'd10);
		add_req(CMD_ASSIGN, 30'd5, 30'd10);
		add_req(CMD_ASSIGN, 30'd6, 30'd10);
		add_req(CMD_ASSIGN, 30'd15, 30'd1);
		add_req(CMD_ASSIGN, 30'd7, 30'd1);
		add_req(CMD_ASSIGN, 30'd3, 30'd1);
		add_req(CMD_REPORT, '0, 30'd1);

		// Zero pool size acts as one server
		set_pool(5'd0);
		add_req(CMD_ASSIGN, 30'd40, 30'd1);
		add_req(CMD_ASSIGN, 30'd41, 30'd1);
		add_req(CMD_REPORT, '0, 30'd1);

		// Oversized setting acts as the full pool; field extremes
		set_pool(5'd31);
		add_req(CMD_ASSIGN, 30'd50, 30'd1);
		add_req(CMD_ASSIGN, 30'd50, 30'd1);
		add_req(CMD_ASSIGN, TIME_MAX, TIME_MAX);
		add_req(CMD_ASSIGN, '0, TIME_MAX);
		add_req(CMD_ASSIGN, TIME_MAX, 30'd1);
		add_req(CMD_REPORT, '0, 30'd1);

		// Random phases, each under a new pool size
		t_now = 100;
		for (int ph = 0; ph < PHASES; ph++) begin
			last_phase = (ph == PHASES - 1);
			case (ph)
				0: pool_v = 5'd1;
				1: pool_v = 5'd16;
				2: pool_v = 5'd2;
				PHASES - 1: pool_v = 5'd16;
				default: pool_v = CFG_W'($urandom_range(0, 31));
			endcase
			set_pool(pool_v);
			// Jump near the top of the time range for the last phase
			if (last_phase) t_now = 32'h3FFF_0000 + $urandom_range(0, 255);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					add_req(CMD_REPORT, TIME_W'($urandom), TIME_W'($urandom_range(1, TIME_MAX)));
				end else begin
					if (r < 17) begin
						arr = t_now - $urandom_range(0, (t_now < 40) ? t_now : 40);
					end else begin
						t_now += $urandom_range(0, 6);
						arr = t_now;
					end
					if (last_phase && $urandom_range(0, 1)) ld = $urandom_range(1, TIME_MAX);
					else ld = $urandom_range(1, 48);
					add_req(CMD_ASSIGN, TIME_W'(arr), TIME_W'(ld));
				end
			end
		end

		// Drain, let the tail of the last item pass, then settle leftovers
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_outcomes.size() != 0) begin
			mismatches += expected_outcomes.size();
			$display("%0t: %0d expected results never arrived", $time, expected_outcomes.size());
		end
		$display("Ran %0d items (%0d reports, %0d dropped requests) under %0d pool settings,",
		         accepted, n_reports, n_drops, n_settings);
		$display("comparing %0d result items with %0d failures.", n_checked, mismatches);
		if (mismatches == 0) begin
			$display("round_robin_server_assigner_tb passed");
		end else begin
			$display("round_robin_server_assigner_tb failed");
		end
		$finish;
	end

endmodule

// File: round_robin_server_assigner.f
design/rrsa_pkg.sv
design/rrsa_cell.sv
design/round_robin_server_assigner.sv
tb/sv/round_robin_server_assigner_tb.sv
